// ===== sv/complex_arithmetic_unit_macros.svh =====
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/cau_pkg.sv =====
// Package: widths, codes, queue entry type and saturation helper.
package cau_pkg;

  localparam int DW     = 16;          // data width
  localparam int FB     = 12;          // fraction bits
  localparam int PW     = 2 * DW;      // product width
  localparam int XW     = 2 * DW + 1;  // sum of products width
  localparam int DENW   = 2 * DW;      // squared magnitude width
  localparam int TW     = 2 * DW + FB; // dividend / quotient width
  localparam int SW     = TW + 1;      // signed pre-saturation width
  localparam int CW     = $clog2(TW + 1);
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Classified item waiting for the back end
  typedef struct packed {
    logic [1:0]             op;
    logic signed [XW-1:0]   x_re;
    logic signed [XW-1:0]   x_im;
    logic [DENW-1:0]        den;
  } entry_t;

  // Clamp to the signed data range; returns {saturated, value}
  function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] maxv;
    logic signed [SW-1:0] minv;
    maxv = '0;
    maxv[DW-2:0] = '1;
    minv = '1;
    minv[DW-2:0] = '0;
    if (v > maxv) return {1'b1, maxv[DW-1:0]};
    if (v < minv) return {1'b1, minv[DW-1:0]};
    return {1'b0, v[DW-1:0]};
  endfunction

endpackage

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: front end, queue, back end.
// Takes two complex Q3.12 operands and an opcode per item and returns one
// rounded, saturated result with status. Add, subtract and multiply take one
// item per cycle while the output is not stalled and no divide is running,
// passing through the queue write, then issue straight into the output
// register. Divide goes through a bit-serial restoring divider that works on
// both components at once, one quotient bit per cycle over 2*DW+FB = 44 bits,
// and holds the back end until it is done; the four-entry queue keeps taking
// items meanwhile until full. A divide by zero takes the fast path with status 1.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_res_re,
  output logic signed [DW-1:0] out_res_im,
  output logic [1:0]           out_status
);

  entry_t ent, head;
  logic   q_full, q_empty, q_pop;

  cau_front u_front (
    .op   (in_op),
    .a_re (in_a_re),
    .a_im (in_a_im),
    .b_re (in_b_re),
    .b_im (in_b_im),
    .ent  (ent)
  );

  assign in_ready = !q_full;

  cau_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_valid && !q_full),
    .din   (ent),
    .pop   (q_pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res_re (out_res_re),
    .out_res_im (out_res_im),
    .out_status (out_status)
  );

endmodule

// ===== sv/cau_front.sv =====
// Front end: forms products and classifies an item into a queue entry.
module cau_front import cau_pkg::*; (
  input  logic [1:0]           op,
  input  logic signed [DW-1:0] a_re,
  input  logic signed [DW-1:0] a_im,
  input  logic signed [DW-1:0] b_re,
  input  logic signed [DW-1:0] b_im,
  output entry_t               ent
);

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;
  logic signed [XW-1:0] den_s;

  // Cross products and divisor squares
  assign p_rr   = a_re * b_re;
  assign p_ii   = a_im * b_im;
  assign p_ri   = a_re * b_im;
  assign p_ir   = a_im * b_re;
  assign p_bb_r = b_re * b_re;
  assign p_bb_i = b_im * b_im;
  assign den_s  = XW'(p_bb_r) + XW'(p_bb_i);

  // Per-operation numerators
  always_comb begin
    ent.op  = op;
    ent.den = den_s[DENW-1:0];
    case (op)
      OP_ADD: begin
        ent.x_re = XW'(a_re) + XW'(b_re);
        ent.x_im = XW'(a_im) + XW'(b_im);
      end
      OP_SUB: begin
        ent.x_re = XW'(a_re) - XW'(b_re);
        ent.x_im = XW'(a_im) - XW'(b_im);
      end
      OP_MUL: begin
        ent.x_re = XW'(p_rr) - XW'(p_ii);
        ent.x_im = XW'(p_ri) + XW'(p_ir);
      end
      default: begin
        ent.x_re = XW'(p_rr) + XW'(p_ii);
        ent.x_im = XW'(p_ir) - XW'(p_ri);
      end
    endcase
  end

endmodule

// ===== sv/cau_fifo.sv =====
// Short queue between front and back ends.
module cau_fifo import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output entry_t dout,
  output logic   full,
  output logic   empty
);

  entry_t          mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    count_r;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== sv/cau_back.sv =====
// Back end: add/sub/mul and divide by zero go straight to the output register, other divides run a bit-serial divider.
module cau_back import cau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  entry_t               head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_res_re,
  output logic signed [DW-1:0] out_res_im,
  output logic [1:0]           out_status
);

`include "complex_arithmetic_unit_macros.svh"

  localparam logic [XW-1:0] HALF = XW'((64'd1 << FB) >> 1);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [TW-1:0]        t_re_r, t_im_r;
  logic [DENW-1:0]      rem_re_r, rem_im_r, den_r;
  logic                 neg_re_r, neg_im_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] out_res_re_r, out_res_im_r;
  logic [1:0]           out_status_r;

  logic                 out_free, div_done, is_div, fast_go, div_go;
  logic [DW:0]          f_re, f_im, d_re, d_im;
  logic signed [XW-1:0] r_re, r_im, m_re, m_im;
  logic [PW-1:0]        mag_re, mag_im;
  logic [DENW+TW-1:0]   s_re, s_im;
  logic signed [SW-1:0] q_re, q_im;

  // One restoring step: {remainder, dividend shifted with quotient bit}
  function automatic logic [DENW+TW-1:0] div_step(input logic [DENW-1:0] rem,
                                                  input logic [TW-1:0] t,
                                                  input logic [DENW-1:0] d);
    logic [DENW:0] rs;
    logic [DENW:0] diff;
    logic          qb;
    rs   = {rem, t[TW-1]};
    diff = rs - {1'b0, d};
    qb   = (rs >= {1'b0, d});
    return {(qb ? diff[DENW-1:0] : rs[DENW-1:0]), t[TW-2:0], qb};
  endfunction

  // Issue control
  assign out_free = !out_valid_r || out_ready;
  assign div_done = busy_r && (cnt_r == CW'(TW));
  assign is_div   = (head.op == OP_DIV) && (head.den != '0);
  assign fast_go  = head_valid && !busy_r && out_free && !is_div;
  assign div_go   = head_valid && !busy_r && is_div;
  assign pop      = fast_go || div_go;

  // Fast result path
  assign r_re = (head.x_re + $signed(HALF)) >>> FB;
  assign r_im = (head.x_im + $signed(HALF)) >>> FB;
  always_comb begin
    case (head.op)
      OP_MUL: begin
        f_re = sat_fn(SW'(r_re));
        f_im = sat_fn(SW'(r_im));
      end
      OP_DIV: begin
        f_re = '0;
        f_im = '0;
      end
      default: begin
        f_re = sat_fn(SW'(head.x_re));
        f_im = sat_fn(SW'(head.x_im));
      end
    endcase
  end

  // Divider load values and step
  assign m_re   = head.x_re[XW-1] ? -head.x_re : head.x_re;
  assign m_im   = head.x_im[XW-1] ? -head.x_im : head.x_im;
  assign mag_re = m_re[PW-1:0];
  assign mag_im = m_im[PW-1:0];
  assign s_re   = div_step(rem_re_r, t_re_r, den_r);
  assign s_im   = div_step(rem_im_r, t_im_r, den_r);

  // Signed, saturated quotient
  assign q_re = neg_re_r ? -$signed({1'b0, t_re_r}) : $signed({1'b0, t_re_r});
  assign q_im = neg_im_r ? -$signed({1'b0, t_im_r}) : $signed({1'b0, t_im_r});
  assign d_re = sat_fn(q_re);
  assign d_im = sat_fn(q_im);

  // Divider datapath
  always_ff @(posedge clk) begin
    if (div_go) begin
      t_re_r   <= (TW'(mag_re) << FB) + TW'(head.den >> 1);
      t_im_r   <= (TW'(mag_im) << FB) + TW'(head.den >> 1);
      rem_re_r <= '0;
      rem_im_r <= '0;
      den_r    <= head.den;
      neg_re_r <= head.x_re[XW-1];
      neg_im_r <= head.x_im[XW-1];
    end else if (busy_r && !div_done) begin
      {rem_re_r, t_re_r} <= s_re;
      {rem_im_r, t_im_r} <= s_im;
    end
  end

  // Divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (div_go) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (div_done && out_free) begin
      busy_r <= 1'b0;
    end else if (busy_r && !div_done) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fast_go || (div_done && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_go) begin
      out_res_re_r <= f_re[DW-1:0];
      out_res_im_r <= f_im[DW-1:0];
      if (head.op == OP_DIV)        out_status_r <= ST_DIVZ;
      else if (f_re[DW] || f_im[DW]) out_status_r <= ST_SAT;
      else                          out_status_r <= ST_OK;
    end else if (div_done && out_free) begin
      out_res_re_r <= d_re[DW-1:0];
      out_res_im_r <= d_im[DW-1:0];
      out_status_r <= (d_re[DW] || d_im[DW]) ? ST_SAT : ST_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_res_re_r;
  assign out_res_im = out_res_im_r;
  assign out_status = out_status_r;

  // Checks
  `CAU_ASSERT_IMPL(a_no_pop_busy, busy_r, !pop)
  `CAU_ASSERT_IMPL(a_divz_zero, out_valid_r && (out_status_r == ST_DIVZ), (out_res_re_r == '0) && (out_res_im_r == '0))
  `CAU_ASSERT_NEXT(a_div_start, div_go, busy_r && (cnt_r == '0))

endmodule
